@@ design/mlps_pkg.sv @@
// shared types, codes and defaults for the multi-level priority stack
package mlps_pkg;

    localparam int LEVELS_DEFAULT      = 5;
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK
    } op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [2:0]         level;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         result_level;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic               level_ok;
        logic signed [31:0] value;
        logic [2:0]         level;
    } work_item_t;

endpackage

@@ design/mlps_front.sv @@
// command front end: accepts transfers and decodes them into work items
module mlps_front
    import mlps_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEFAULT
) (
    input  logic       start,
    input  in_item_t   command,
    input  logic       queue_full,
    output logic       busy,
    output logic       push,
    output work_item_t item
);

    localparam logic [3:0] LEVEL_LIMIT = 4'(LEVELS);

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        item.value    = command.value;
        item.level    = command.level;
        item.level_ok = ({1'b0, command.level} < LEVEL_LIMIT);
        unique case (command.cmd)
            CMD_PUSH: item.op = OP_PUSH;
            CMD_POP:  item.op = OP_POP;
            default:  item.op = OP_PEEK;
        endcase
    end

endmodule

@@ design/mlps_queue.sv @@
// short fifo of decoded work items between front and back
module mlps_queue
    import mlps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  work_item_t push_item,
    input  logic       pop,
    output work_item_t head,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/mlps_back.sv @@
// execution back end: level counters, stack memory and result register
module mlps_back
    import mlps_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEFAULT,
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  work_item_t item,
    input  logic       queue_empty,
    output logic       pop,
    output logic       done,
    output out_item_t  result
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int WORDS  = LEVELS * STACK_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [CNT_W-1:0] count_next [LEVELS];
    logic [LVL_W-1:0] rd_level_reg, rd_level_next;
    logic             done_reg, done_next;
    out_item_t        result_reg, result_next;

    logic signed [31:0] mem [WORDS];
    logic signed [31:0] rd_data_reg;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    logic             top_found;
    logic [LVL_W-1:0] top_level;
    logic [LVL_W-1:0] push_idx;

    assign done     = done_reg;
    assign result   = result_reg;
    assign push_idx = item.level[LVL_W-1:0];

    // highest non-empty level
    always_comb
    begin
        top_found = 1'b0;
        top_level = '0;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (count_reg[lv] != '0)
            begin
                top_found = 1'b1;
                top_level = LVL_W'(lv);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_level_next = rd_level_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = ADDR_W'(int'(push_idx) * STACK_DEPTH) + ADDR_W'(count_reg[push_idx]);
        rd_addr       = ADDR_W'(int'(top_level) * STACK_DEPTH)
                        + ADDR_W'(count_reg[top_level] - 1'b1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (item.op == OP_PUSH)
                    begin
                        done_next                = 1'b1;
                        result_next.result_value = '0;
                        result_next.result_level = item.level;
                        result_next.status       = ST_FULL;
                        if (item.level_ok)
                        begin
                            if (count_reg[push_idx] != CNT_W'(STACK_DEPTH))
                            begin
                                wr_en                = 1'b1;
                                count_next[push_idx] = count_reg[push_idx] + 1'b1;
                                result_next.status   = ST_OK;
                            end
                        end
                    end
                    else if (!top_found)
                    begin
                        done_next                = 1'b1;
                        result_next.result_value = '0;
                        result_next.result_level = '0;
                        result_next.status       = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_level_next = top_level;
                        state_next    = S_READ;
                        if (item.op == OP_POP)
                        begin
                            count_next[top_level] = count_reg[top_level] - 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                done_next                = 1'b1;
                result_next.result_value = rd_data_reg;
                result_next.result_level = 3'(rd_level_reg);
                result_next.status       = ST_OK;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '{default: '0};
            rd_level_reg <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_level_reg <= rd_level_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

endmodule

@@ design/multi_level_priority_stack.sv @@
// top level of the multi-level priority stack
// One bounded LIFO per priority level. A command is taken when start is high
// and busy is low; each command gives exactly one result, shown on result for
// one cycle with done high, and the receiver cannot stall it. A taken push
// passes the queue register and then the result register before done rises,
// and the back end can finish one push per cycle while no pop or peek is in
// its read state; a pop or peek also passes the registered read of the stack
// memory, which holds the back end in that read state. A two-entry queue
// between decode and execution absorbs this; busy is high while that queue
// is full. No clearing pass is needed after reset: level counters reset to
// zero and only written words are ever read.
module multi_level_priority_stack
    import mlps_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEFAULT,
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  command,
    output logic      busy,
    output logic      done,
    output out_item_t result
);

    work_item_t front_item;
    work_item_t head_item;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    mlps_front #(
        .LEVELS(LEVELS)
    ) u_front (
        .start     (start),
        .command   (command),
        .queue_full(q_full),
        .busy      (busy),
        .push      (q_push),
        .item      (front_item)
    );

    mlps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(front_item),
        .pop      (q_pop),
        .head     (head_item),
        .empty    (q_empty),
        .full     (q_full)
    );

    mlps_back #(
        .LEVELS     (LEVELS),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .queue_empty(q_empty),
        .pop        (q_pop),
        .done       (done),
        .result     (result)
    );

endmodule
